// ===== sv/ehp_pkg.sv =====
// Shared types, constants and helper functions for the ELF header field parser.
`default_nettype none

package ehp_pkg;

  localparam int unsigned PosW        = 7;
  localparam int unsigned MinHdrBytes = 52;
  localparam int unsigned Hdr32Bytes  = 52;
  localparam int unsigned Hdr64Bytes  = 64;
  localparam int unsigned TypeOffset  = 16;
  localparam int unsigned MachOffset  = 18;
  localparam int unsigned EntryOffset = 24;
  localparam int unsigned OutDataW    = 128;

  localparam logic [7:0] ClassElf32 = 8'd1;
  localparam logic [7:0] EncBig     = 8'd2;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_SMALL = 2'd1,
    ERR_MAGIC     = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  // Snapshot of the captured header handed from the capture stage to the formatter.
  typedef struct packed {
    logic        emit;
    err_e        err;
    logic [7:0]  class_byte;
    logic [7:0]  enc_byte;
    logic [7:0]  ver_byte;
    logic [15:0] type_bytes;
    logic [15:0] mach_bytes;
    logic [63:0] entry_bytes;
  } cap_t;

  typedef struct packed {
    logic [63:0] entry_address;
    logic [15:0] machine_code;
    logic [15:0] object_type;
    logic [7:0]  ident_version;
    logic [7:0]  data_encoding;
    logic [7:0]  file_class;
    err_e        error_code;
    logic        header_valid;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0:    m = 8'h7F;
      2'd1:    m = 8'h45;
      2'd2:    m = 8'h4C;
      default: m = 8'h46;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/ehp_capture.sv =====
// Byte counter, magic check and header field capture for the ELF header parser.
`default_nettype none

module ehp_capture import ehp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output cap_t            cap_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            magic_ok_q, magic_ok_d;
  logic [7:0]      class_q, class_d;
  logic [7:0]      enc_q, enc_d;
  logic [7:0]      ver_q, ver_d;
  logic [15:0]     type_q, type_d;
  logic [15:0]     mach_q, mach_d;
  logic [63:0]     entry_q, entry_d;
  logic            given_q, given_d;

  logic [PosW-1:0] count;
  logic [PosW-1:0] hdr_len;
  logic            done;
  logic            emit;
  err_e            err;

  always_comb begin
    magic_ok_d = magic_ok_q;
    class_d    = class_q;
    enc_d      = enc_q;
    ver_d      = ver_q;
    type_d     = type_q;
    mach_d     = mach_q;
    entry_d    = entry_q;

    if (!given_q) begin
      if (pos_q < PosW'(4)) begin
        if (byte_i != magic_byte(pos_q[1:0])) begin
          magic_ok_d = 1'b0;
        end
      end else if (pos_q == PosW'(4)) begin
        class_d = byte_i;
      end else if (pos_q == PosW'(5)) begin
        enc_d = byte_i;
      end else if (pos_q == PosW'(6)) begin
        ver_d = byte_i;
      end else if (pos_q == PosW'(TypeOffset)) begin
        type_d[7:0] = byte_i;
      end else if (pos_q == PosW'(TypeOffset + 1)) begin
        type_d[15:8] = byte_i;
      end else if (pos_q == PosW'(MachOffset)) begin
        mach_d[7:0] = byte_i;
      end else if (pos_q == PosW'(MachOffset + 1)) begin
        mach_d[15:8] = byte_i;
      end else if (pos_q >= PosW'(EntryOffset) && pos_q < PosW'(EntryOffset + 8)) begin
        entry_d[8*pos_q[2:0] +: 8] = byte_i;
      end
    end

    count   = pos_q + PosW'(1);
    hdr_len = (class_d == ClassElf32) ? PosW'(Hdr32Bytes) : PosW'(Hdr64Bytes);
    done    = (count >= hdr_len);
    emit    = !given_q && (done || last_i);

    if (count < PosW'(MinHdrBytes)) begin
      err = ERR_TOO_SMALL;
    end else if (!magic_ok_d) begin
      err = ERR_MAGIC;
    end else if (!done) begin
      err = ERR_TRUNCATED;
    end else begin
      err = ERR_NONE;
    end

    pos_d   = given_q ? pos_q : count;
    given_d = given_q || emit;
  end

  // The last byte of a file rearms the parser for the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      magic_ok_q <= 1'b1;
      class_q    <= '0;
      enc_q      <= '0;
      ver_q      <= '0;
      type_q     <= '0;
      mach_q     <= '0;
      entry_q    <= '0;
      given_q    <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        pos_q      <= '0;
        magic_ok_q <= 1'b1;
        class_q    <= '0;
        enc_q      <= '0;
        ver_q      <= '0;
        type_q     <= '0;
        mach_q     <= '0;
        entry_q    <= '0;
        given_q    <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        magic_ok_q <= magic_ok_d;
        class_q    <= class_d;
        enc_q      <= enc_d;
        ver_q      <= ver_d;
        type_q     <= type_d;
        mach_q     <= mach_d;
        entry_q    <= entry_d;
        given_q    <= given_d;
      end
    end
  end

  assign cap_o.emit        = take_i && emit;
  assign cap_o.err         = err;
  assign cap_o.class_byte  = class_d;
  assign cap_o.enc_byte    = enc_d;
  assign cap_o.ver_byte    = ver_d;
  assign cap_o.type_bytes  = type_d;
  assign cap_o.mach_bytes  = mach_d;
  assign cap_o.entry_bytes = entry_d;

endmodule

`default_nettype wire

// ===== sv/ehp_format.sv =====
// Byte-order correction and error masking of the captured header fields.
`default_nettype none

module ehp_format import ehp_pkg::*; (
  input  cap_t    cap_i,
  output result_t res_o
);

  logic        big;
  logic        is32;
  logic [63:0] entry;

  always_comb begin
    big  = (cap_i.enc_byte == EncBig);
    is32 = (cap_i.class_byte == ClassElf32);
    if (is32) begin
      entry = {32'd0, big ? swap32(cap_i.entry_bytes[31:0]) : cap_i.entry_bytes[31:0]};
    end else begin
      entry = big ? swap64(cap_i.entry_bytes) : cap_i.entry_bytes;
    end

    res_o            = '0;
    res_o.error_code = cap_i.err;
    if (cap_i.err == ERR_NONE) begin
      res_o.header_valid  = 1'b1;
      res_o.file_class    = cap_i.class_byte;
      res_o.data_encoding = cap_i.enc_byte;
      res_o.ident_version = cap_i.ver_byte;
      res_o.object_type   = big ? swap16(cap_i.type_bytes) : cap_i.type_bytes;
      res_o.machine_code  = big ? swap16(cap_i.mach_bytes) : cap_i.mach_bytes;
      res_o.entry_address = entry;
    end
  end

endmodule

`default_nettype wire

// ===== sv/elf_header_field_parser.sv =====
// Top level of the ELF header field parser: byte stream in, one header result out.
//
//   Channel   Direction  Fields (lowest bit first)
//   s_axis    in         tdata: data_byte; tlast: last_byte
//   m_axis    out        tdata: header_valid, error_code, file_class, data_encoding,
//                               ident_version, object_type, machine_code, entry_address
//
// One byte is taken per cycle; a result appears in the cycle after the byte that completes
// the header or ends a stream before that has been taken. While a result waits and m_axis_tready is
// low, the input is held off; a byte is still taken in a cycle in which the waiting result
// is taken. Reset clears the byte count, the captured fields and the result register.
`default_nettype none

module elf_header_field_parser import ehp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,   // data_byte
  input  wire logic                s_axis_tlast_i,   // last_byte
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o    // header_valid, error_code, file_class,
                                                     // data_encoding, ident_version,
                                                     // object_type, machine_code,
                                                     // entry_address, zero padding
);

  logic    take;
  cap_t    cap;
  result_t res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  ehp_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .cap_o  (cap)
  );

  ehp_format u_format (
    .cap_i (cap),
    .res_o (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cap.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cap.emit) begin
        res_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - $bits(result_t))'(0), res_q};

endmodule

`default_nettype wire
